FILE: hdl/ssp_pkg.sv
package ssp_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned DistW  = 12;
  localparam int unsigned StepW  = 8;
  localparam int unsigned DelayW = 10;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned ArithW = PosW + 3;

  localparam logic [PosW-1:0]   CenterRst = 16'hF9F0;
  localparam logic [DistW-1:0]  DistRst   = 12'd200;
  localparam logic [StepW-1:0]  StepRst   = 8'd10;
  localparam logic [DelayW-1:0] DelayRst  = 10'd500;
  localparam logic [PosW-1:0]   PosRst    = CenterRst - PosW'(DistRst);
  localparam logic [PosW-1:0]   PosMax    = '1;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [1:0] {
    REG_CENTER = 2'd0,
    REG_DIST   = 2'd1,
    REG_STEP   = 2'd2,
    REG_DELAY  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_FINE  = 1'b1
  } op_e;

  typedef struct packed {
    logic            op;
    logic            dir;
    logic            mid;
  } item_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            relay;
    logic            low_lamp;
    logic            high_lamp;
    logic            drive_en;
    logic            pulse;
  } res_t;

endpackage

FILE: hdl/ssp_core.sv
module ssp_core
  import ssp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_idx_e            cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                step_i,
  input  item_t               item_i,
  output res_t                res_o
);

  logic [PosW-1:0]   center_q;
  logic [DistW-1:0]  dist_q;
  logic [StepW-1:0]  step_q;
  logic [DelayW-1:0] delay_q;

  logic [PosW-1:0]   pos_q, pos_d;
  logic [DelayW-1:0] en_cnt_q, en_cnt_d;
  logic              en_flag_q, en_flag_d;
  logic [PosW-1:0]   pcnt_q, pcnt_d;
  logic              pact_q, pact_d;
  logic              hi_lamp_q, hi_lamp_d;
  logic              lo_lamp_q, lo_lamp_d;
  logic              relay_q, relay_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CenterRst;
      dist_q   <= DistRst;
      step_q   <= StepRst;
      delay_q  <= DelayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER: center_q <= cfg_data_i[PosW-1:0];
        REG_DIST:   dist_q   <= cfg_data_i[DistW-1:0];
        REG_STEP:   step_q   <= cfg_data_i[StepW-1:0];
        REG_DELAY:  delay_q  <= cfg_data_i[DelayW-1:0];
        default:    ;
      endcase
    end
  end

  logic signed [ArithW-1:0] ctr_s, hi_s, lo_s, pos_s, npos_s;
  logic [PosW:0]            up_sum;
  logic signed [ArithW-1:0] dn_diff;

  always_comb begin
    ctr_s   = $signed({3'b000, center_q});
    hi_s    = ctr_s + $signed(ArithW'(dist_q));
    lo_s    = ctr_s - $signed(ArithW'(dist_q));
    pos_s   = $signed({3'b000, pos_q});
    up_sum  = {1'b0, pos_q} + (PosW+1)'(step_q);
    dn_diff = pos_s - $signed(ArithW'(step_q));

    en_cnt_d  = en_cnt_q;
    en_flag_d = en_flag_q;
    pos_d     = pos_q;
    pcnt_d    = pcnt_q;
    pact_d    = pact_q;
    hi_lamp_d = hi_lamp_q;
    lo_lamp_d = lo_lamp_q;
    relay_d   = relay_q;
    npos_s    = pos_s;

    if (item_i.op == OP_FRAME) begin
      if (en_cnt_q < delay_q) begin
        en_cnt_d = en_cnt_q + DelayW'(1);
      end else begin
        en_flag_d = 1'b1;
      end

      if (!item_i.dir && !item_i.mid && pos_s < hi_s) begin
        pos_d = up_sum[PosW] ? PosMax : up_sum[PosW-1:0];
      end else if (item_i.dir && !item_i.mid && pos_s > lo_s) begin
        pos_d = dn_diff[ArithW-1] ? '0 : dn_diff[PosW-1:0];
      end else if (item_i.mid) begin
        pos_d = center_q;
      end
      npos_s = $signed({3'b000, pos_d});

      if (npos_s < hi_s - ArithW'(1) && npos_s > lo_s + ArithW'(1)) begin
        hi_lamp_d = 1'b0;
        lo_lamp_d = 1'b0;
      end else if (npos_s >= hi_s) begin
        hi_lamp_d = 1'b1;
        lo_lamp_d = 1'b0;
      end else if (npos_s <= lo_s) begin
        hi_lamp_d = 1'b0;
        lo_lamp_d = 1'b1;
      end

      if (pos_d > center_q) begin
        relay_d = 1'b0;
      end else if (pos_d < center_q) begin
        relay_d = 1'b1;
      end

      pcnt_d = pos_d;
      pact_d = 1'b1;
    end else if (pact_q) begin
      if (pcnt_q == PosMax) begin
        pcnt_d = '0;
        pact_d = 1'b0;
      end else begin
        pcnt_d = pcnt_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= PosRst;
      en_cnt_q  <= '0;
      en_flag_q <= 1'b0;
      pcnt_q    <= CenterRst;
      pact_q    <= 1'b0;
      hi_lamp_q <= 1'b0;
      lo_lamp_q <= 1'b0;
      relay_q   <= 1'b0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      en_cnt_q  <= en_cnt_d;
      en_flag_q <= en_flag_d;
      pcnt_q    <= pcnt_d;
      pact_q    <= pact_d;
      hi_lamp_q <= hi_lamp_d;
      lo_lamp_q <= lo_lamp_d;
      relay_q   <= relay_d;
    end
  end

  assign res_o.position  = pos_d;
  assign res_o.relay     = relay_d;
  assign res_o.low_lamp  = lo_lamp_d;
  assign res_o.high_lamp = hi_lamp_d;
  assign res_o.drive_en  = en_flag_d;
  assign res_o.pulse     = pact_d;

endmodule

FILE: hdl/servo_slew_pulse_generator.sv
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tdata: direction_switch, middle_switch, pad to 8 / tuser: op
// m_axis    out  tdata: pulse_level, drive_enabled, high_end_lamp, low_end_lamp,
//                       polarity_relay, position[15:0], pad to 24
// cfg       in   cfg_we_i, cfg_idx_i (register index), cfg_data_i
//
// One beat per cycle sustained while m_axis_tready is high.
// Input register, then one pass through the state update into the output register.
// State advances when the input register hands its beat to the output register.
// rst_ni asynchronously returns the valid flags and core state to their reset values;
// the input item and result data registers are not reset. A stalled m_axis holds the
// result; s_axis keeps taking beats until the input register is also full.
module servo_slew_pulse_generator
  import ssp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // direction_switch, middle_switch
  input  logic                s_axis_tuser,   // op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // pulse_level, drive_enabled,
                                              // high_end_lamp, low_end_lamp,
                                              // polarity_relay, position
);

  logic  in_valid_q, in_valid_d;
  item_t in_item_q;
  logic  out_valid_q, out_valid_d;
  res_t  out_res_q;
  res_t  res;
  logic  advance, s_acc;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_acc) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_item_q.op  <= s_axis_tuser;
      in_item_q.dir <= s_axis_tdata[0];
      in_item_q.mid <= s_axis_tdata[1];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  ssp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .item_i     (in_item_q),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q};

endmodule

FILE: hdl/ssp_checker.sv
module ssp_checker
  import ssp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_lamps_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[3]))
    else $error("both end lamps lit");

  a_enable_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[1]
      |=> !m_axis_tvalid || m_axis_tdata[1])
    else $error("drive enable dropped");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind servo_slew_pulse_generator ssp_checker u_ssp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
